FILE: rtl/b64_pkg.sv
// Shared types, character constants and alphabet functions for the Base64 codec.
// Used by b64_core, b64_out_buf and base64_stream_codec; depends on nothing.
package b64_pkg;

  localparam int unsigned MaxResults = 4;
  localparam int unsigned CntW       = 3;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic [7:0] CHAR_PAD   = 8'h3D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
  localparam logic [7:0] CHAR_DIG_0 = 8'h30;
  localparam logic [7:0] CHAR_DIG_9 = 8'h39;

  typedef struct packed {
    logic [CntW-1:0]             count;
    logic [MaxResults-1:0][7:0]  chars;
  } b64_res_t;

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] r;
    r = 8'h00;
    priority if (v < 6'd26) begin
      r = 8'(CHAR_UP_A + {2'b00, v});
    end else if (v < 6'd52) begin
      r = 8'(CHAR_LO_A + {2'b00, v} - 8'd26);
    end else if (v < 6'd62) begin
      r = 8'(CHAR_DIG_0 + {2'b00, v} - 8'd52);
    end else if (v == 6'd62) begin
      r = CHAR_PLUS;
    end else begin
      r = CHAR_SLASH;
    end
    return r;
  endfunction

  function automatic logic [5:0] dec_sextet(input logic [7:0] c);
    logic [5:0] r;
    r = 6'd0;
    priority if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
      r = 6'(c - CHAR_UP_A);
    end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
      r = 6'(c - CHAR_LO_A + 8'd26);
    end else if (c >= CHAR_DIG_0 && c <= CHAR_DIG_9) begin
      r = 6'(c - CHAR_DIG_0 + 8'd52);
    end else if (c == CHAR_PLUS) begin
      r = 6'd62;
    end else if (c == CHAR_SLASH) begin
      r = 6'd63;
    end else begin
      r = 6'd0;
    end
    return r;
  endfunction

endpackage

FILE: rtl/base64_stream_codec.sv
// Top level of the streaming Base64 codec: mode register, group logic and result
// register. Depends on b64_pkg, b64_core and b64_out_buf.
//
// Usage:
// The cfg_ channel writes the one-bit mode: 0 encodes bytes to characters, 1 decodes
// characters to bytes. cfg_ready is always high; write only while the block is idle.
// Each request on the in_ channel carries one byte and an end-of-stream flag.
// It yields zero to four result bytes on the out_ channel, one per cycle while the
// receiver is ready, and out_end_of_run marks the last byte of each request.
// The first result byte appears in the cycle after acceptance. A request that
// yields more than one byte holds in_ready low until its last byte is taken, so
// the block takes one request per cycle while the receiver is ready when each
// yields at most one byte; otherwise the single output port limits the rate.
// Requests that yield nothing never stall the input.
// Reset selects encode mode, clears the group position and leftover bits and
// empties the result register. When the receiver stalls, the current byte holds
// and in_ready stays low until the last byte of the pending request is taken.
module base64_stream_codec (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_mode,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_stream,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_end_of_run
);
  import b64_pkg::*;

  logic     mode_r;
  logic     in_fire;
  b64_res_t res;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ENCODE;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_mode;
    end
  end

  b64_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .mode          (mode_r),
    .load          (in_fire),
    .data_byte     (in_data_byte),
    .end_of_stream (in_end_of_stream),
    .res           (res)
  );

  b64_out_buf u_out_buf (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (in_fire),
    .res            (res),
    .out_ready      (out_ready),
    .can_load       (in_ready),
    .out_valid      (out_valid),
    .out_byte       (out_byte),
    .out_end_of_run (out_end_of_run)
  );

`ifndef SYNTHESIS
  a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_end_of_run |=> out_valid)
    else $error("result bytes of a request were lost");

  a_accept_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && out_valid |-> out_end_of_run && out_ready)
    else $error("new request accepted while earlier results remain");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_byte))
    else $error("stalled result byte changed");
`endif

endmodule

FILE: rtl/b64_core.sv
// Group position and leftover bits, and the logic that turns one request into
// up to four result bytes. Depends on b64_pkg.
module b64_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              mode,
  input  logic              load,
  input  logic [7:0]        data_byte,
  input  logic              end_of_stream,
  output b64_pkg::b64_res_t res
);
  import b64_pkg::*;

  logic [1:0] pos_r, pos_nxt;
  logic [5:0] carry_r, carry_nxt;
  logic [5:0] v;

  always_comb begin
    res       = '0;
    pos_nxt   = pos_r;
    carry_nxt = carry_r;
    v         = dec_sextet(data_byte);
    if (mode == MODE_ENCODE) begin
      unique case (pos_r)
        2'd0: begin
          res.chars[0] = enc_char(data_byte[7:2]);
          res.count    = 3'd1;
          pos_nxt      = 2'd1;
          carry_nxt    = {4'b0000, data_byte[1:0]};
        end
        2'd1: begin
          res.chars[0] = enc_char({carry_r[1:0], data_byte[7:4]});
          res.count    = 3'd1;
          pos_nxt      = 2'd2;
          carry_nxt    = {2'b00, data_byte[3:0]};
        end
        default: begin
          res.chars[0] = enc_char({carry_r[3:0], data_byte[7:6]});
          res.chars[1] = enc_char(data_byte[5:0]);
          res.count    = 3'd2;
          pos_nxt      = 2'd0;
          carry_nxt    = 6'd0;
        end
      endcase
      if (end_of_stream) begin
        if (pos_nxt == 2'd1) begin
          res.chars[1] = enc_char({carry_nxt[1:0], 4'b0000});
          res.chars[2] = CHAR_PAD;
          res.chars[3] = CHAR_PAD;
          res.count    = 3'd4;
        end else if (pos_nxt == 2'd2) begin
          res.chars[1] = enc_char({carry_nxt[3:0], 2'b00});
          res.chars[2] = CHAR_PAD;
          res.count    = 3'd3;
        end
      end
    end else if (data_byte != CHAR_PAD) begin
      unique case (pos_r)
        2'd0: begin
          pos_nxt   = 2'd1;
          carry_nxt = v;
        end
        2'd1: begin
          res.chars[0] = {carry_r, v[5:4]};
          res.count    = 3'd1;
          pos_nxt      = 2'd2;
          carry_nxt    = {2'b00, v[3:0]};
        end
        2'd2: begin
          res.chars[0] = {carry_r[3:0], v[5:2]};
          res.count    = 3'd1;
          pos_nxt      = 2'd3;
          carry_nxt    = {4'b0000, v[1:0]};
        end
        default: begin
          res.chars[0] = {carry_r[1:0], v};
          res.count    = 3'd1;
          pos_nxt      = 2'd0;
          carry_nxt    = 6'd0;
        end
      endcase
    end
    if (end_of_stream) begin
      pos_nxt   = 2'd0;
      carry_nxt = 6'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 2'd0;
      carry_r <= 6'd0;
    end else if (load) begin
      pos_r   <= pos_nxt;
      carry_r <= carry_nxt;
    end
  end

endmodule

FILE: rtl/b64_out_buf.sv
// Result register that holds the bytes of one request and hands them out one per
// cycle while the receiver is ready, marking the last one. Depends on b64_pkg.
module b64_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  b64_pkg::b64_res_t res,
  input  logic              out_ready,
  output logic              can_load,
  output logic              out_valid,
  output logic [7:0]        out_byte,
  output logic              out_end_of_run
);
  import b64_pkg::*;

  logic [CntW-1:0]            cnt_r, cnt_nxt;
  logic [MaxResults-1:0][7:0] data_r, data_nxt;
  logic                       pop;

  assign out_valid      = (cnt_r != '0);
  assign out_byte       = data_r[0];
  assign out_end_of_run = (cnt_r == CntW'(1));
  assign pop            = out_valid && out_ready;
  assign can_load       = (cnt_r == '0) || (out_end_of_run && out_ready);

  always_comb begin
    cnt_nxt  = cnt_r;
    data_nxt = data_r;
    if (load) begin
      cnt_nxt  = res.count;
      data_nxt = res.chars;
    end else if (pop) begin
      cnt_nxt  = cnt_r - CntW'(1);
      data_nxt = {8'h00, data_r[MaxResults-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule
